FILE: design/adc_pkg.sv
// Shared types, widths and constants of the arcade drive conditioner.
// All design files but adc_checker refer to this package by scoped names.
package adc_pkg;

    // Q1.14 fixed point throughout.
    localparam int FRAC_W     = 14;
    localparam int AXIS_W     = 16;               // input axis and output drive width
    localparam int TICK_W     = 16;               // elapsed tick count width
    localparam int MAG_W      = FRAC_W + 1;       // saturated magnitude, up to 1.0
    localparam int LIM_W      = FRAC_W + 2;       // slew limit, up to 2.0
    localparam int RAD_W      = 2 * FRAC_W + 1;   // square root radicand
    localparam int STATE_W    = FRAC_W + 3;       // shaped and limited axis, signed
    localparam int PROD_W     = AXIS_W + 1;       // scaled side magnitude

    localparam int DB_W       = 13;
    localparam int STEP_W     = 15;
    localparam int COEF_W     = 15;
    localparam int CFG_DATA_W = 15;
    localparam int CFG_IDX_W  = 3;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [MAG_W-1:0]  ONE_MAG = {1'b1, {FRAC_W{1'b0}}};
    localparam logic [LIM_W-1:0]  LIM_MAX = {1'b1, {(FRAC_W + 1){1'b0}}};

    localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(98);
    localparam logic [COEF_W-1:0] GAIN_RESET = COEF_W'(ONE_MAG);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DB_SPEED     = 3'd0,
        REG_DB_TURN      = 3'd1,
        REG_MAX_STEP     = 3'd2,
        REG_LEFT_GAIN    = 3'd3,
        REG_LEFT_OFFSET  = 3'd4,
        REG_RIGHT_GAIN   = 3'd5,
        REG_RIGHT_OFFSET = 3'd6
    } cfg_index_t;

    typedef struct packed {
        logic [DB_W-1:0]   db_speed;
        logic [DB_W-1:0]   db_turn;
        logic [STEP_W-1:0] max_step;
        logic [COEF_W-1:0] left_gain;
        logic [COEF_W-1:0] left_offset;
        logic [COEF_W-1:0] right_gain;
        logic [COEF_W-1:0] right_offset;
    } cfg_t;

    // One classified item as it waits between the front and the back.
    typedef struct packed {
        logic [MAG_W-1:0] speed_mag;
        logic             speed_neg;
        logic [MAG_W-1:0] turn_mag;
        logic             turn_neg;
        logic [LIM_W-1:0] limit;
    } item_t;

endpackage

FILE: design/arcade_drive_conditioner_core.sv
// Top level of the arcade drive conditioner: configuration registers, front,
// item queue and back. Depends on adc_pkg, adc_front, adc_queue and adc_back.
//
//   channel  | handshake            | payload
//   ---------+----------------------+------------------------------------------
//   input    | in_valid / in_stall  | speed_axis, turn_axis, elapsed_ticks
//   output   | out_valid / out_stall| left_drive, right_drive
//   config   | cfg_write            | cfg_index, cfg_data
//
// In the back an item leaves the queue and is squared, then both axes take their
// square roots side by side, one iteration per two radicand bits; once the roots
// are seen to finish, the item is shaped, slewed and mixed, scaled and output.
// Reset is asynchronous; it clears the last axis values and the queue at once.
// The two-entry queue takes transfers until it is full while the output is stalled.
// A stalled result holds the back in its output state until the transfer.
module arcade_drive_conditioner_core (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic signed [adc_pkg::AXIS_W-1:0]     speed_axis,
    input  logic signed [adc_pkg::AXIS_W-1:0]     turn_axis,
    input  logic        [adc_pkg::TICK_W-1:0]     elapsed_ticks,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [adc_pkg::AXIS_W-1:0]     left_drive,
    output logic signed [adc_pkg::AXIS_W-1:0]     right_drive,
    input  logic                                  cfg_write,
    input  logic        [adc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic        [adc_pkg::CFG_DATA_W-1:0] cfg_data
);

    adc_pkg::cfg_t  cfg_reg, cfg_next;
    adc_pkg::item_t front_item, head_item;
    logic           queue_full, queue_empty, pop;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (adc_pkg::cfg_index_t'(cfg_index))
                adc_pkg::REG_DB_SPEED:     cfg_next.db_speed     = cfg_data[adc_pkg::DB_W-1:0];
                adc_pkg::REG_DB_TURN:      cfg_next.db_turn      = cfg_data[adc_pkg::DB_W-1:0];
                adc_pkg::REG_MAX_STEP:     cfg_next.max_step     = cfg_data;
                adc_pkg::REG_LEFT_GAIN:    cfg_next.left_gain    = cfg_data;
                adc_pkg::REG_LEFT_OFFSET:  cfg_next.left_offset  = cfg_data;
                adc_pkg::REG_RIGHT_GAIN:   cfg_next.right_gain   = cfg_data;
                adc_pkg::REG_RIGHT_OFFSET: cfg_next.right_offset = cfg_data;
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.db_speed     <= '0;
            cfg_reg.db_turn      <= '0;
            cfg_reg.max_step     <= adc_pkg::STEP_RESET;
            cfg_reg.left_gain    <= adc_pkg::GAIN_RESET;
            cfg_reg.left_offset  <= '0;
            cfg_reg.right_gain   <= adc_pkg::GAIN_RESET;
            cfg_reg.right_offset <= '0;
        end
        else
            cfg_reg <= cfg_next;
    end

    assign in_stall = queue_full;

    adc_front u_front (
        .cfg           (cfg_reg),
        .speed_axis    (speed_axis),
        .turn_axis     (turn_axis),
        .elapsed_ticks (elapsed_ticks),
        .item          (front_item)
    );

    adc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_valid && !queue_full),
        .push_item (front_item),
        .pop       (pop),
        .head_item (head_item),
        .full      (queue_full),
        .empty     (queue_empty)
    );

    adc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .head_item   (head_item),
        .queue_empty (queue_empty),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .left_drive  (left_drive),
        .right_drive (right_drive)
    );

endmodule

FILE: design/adc_front.sv
// Front end of the arcade drive conditioner: deadband, magnitude saturation
// and slew limit of one incoming item. Depends on adc_pkg.
module adc_front (
    input  adc_pkg::cfg_t                      cfg,
    input  logic signed [adc_pkg::AXIS_W-1:0]  speed_axis,
    input  logic signed [adc_pkg::AXIS_W-1:0]  turn_axis,
    input  logic        [adc_pkg::TICK_W-1:0]  elapsed_ticks,
    output adc_pkg::item_t                     item
);

    // The magnitude is taken before saturation so that the deadband sees the raw axis.
    function automatic logic [adc_pkg::MAG_W-1:0] axis_mag(
        input logic signed [adc_pkg::AXIS_W-1:0] x,
        input logic        [adc_pkg::DB_W-1:0]   db
    );
        logic [adc_pkg::AXIS_W-1:0] a;
        logic [adc_pkg::MAG_W-1:0]  m;
        a = x[adc_pkg::AXIS_W-1] ? adc_pkg::AXIS_W'(-x) : adc_pkg::AXIS_W'(x);
        if (a < adc_pkg::AXIS_W'(db))
            m = '0;
        else if (a > adc_pkg::AXIS_W'(adc_pkg::ONE_MAG))
            m = adc_pkg::ONE_MAG;
        else
            m = a[adc_pkg::MAG_W-1:0];
        return m;
    endfunction

    logic [adc_pkg::STEP_W+adc_pkg::TICK_W-1:0] step_prod;

    assign step_prod = cfg.max_step * elapsed_ticks;

    always_comb
    begin
        item.speed_mag = axis_mag(speed_axis, cfg.db_speed);
        item.speed_neg = speed_axis[adc_pkg::AXIS_W-1];
        item.turn_mag  = axis_mag(turn_axis, cfg.db_turn);
        item.turn_neg  = turn_axis[adc_pkg::AXIS_W-1];
        if (step_prod > (adc_pkg::STEP_W + adc_pkg::TICK_W)'(adc_pkg::LIM_MAX))
            item.limit = adc_pkg::LIM_MAX;
        else
            item.limit = step_prod[adc_pkg::LIM_W-1:0];
    end

endmodule

FILE: design/adc_queue.sv
// Short item queue between the front and the back of the conditioner.
// Depends on adc_pkg for the item type and the depth.
module adc_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  adc_pkg::item_t push_item,
    input  logic           pop,
    output adc_pkg::item_t head_item,
    output logic           full,
    output logic           empty
);

    adc_pkg::item_t              mem_reg [adc_pkg::QUEUE_DEPTH];
    logic [adc_pkg::QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [adc_pkg::QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [adc_pkg::QCNT_W-1:0]  count_reg, count_next;

    localparam logic [adc_pkg::QPTR_W-1:0] LAST_PTR = adc_pkg::QPTR_W'(adc_pkg::QUEUE_DEPTH - 1);

    assign full      = (count_reg == adc_pkg::QCNT_W'(adc_pkg::QUEUE_DEPTH));
    assign empty     = (count_reg == '0);
    assign head_item = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

endmodule

FILE: design/adc_isqrt.sv
// Floor integer square root, two radicand bits per cycle.
// Depends on adc_pkg for the radicand width.
module adc_isqrt (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [adc_pkg::RAD_W-1:0]  radicand,
    output logic                       busy,
    output logic [adc_pkg::MAG_W-1:0]  root
);

    logic [adc_pkg::RAD_W-1:0] rem_reg, rem_next;
    logic [adc_pkg::RAD_W-1:0] root_reg, root_next;
    logic [adc_pkg::RAD_W-1:0] bit_reg, bit_next;
    logic                      busy_reg, busy_next;
    logic [adc_pkg::RAD_W:0]   trial;

    localparam logic [adc_pkg::RAD_W-1:0] TOP_BIT = {1'b1, {(adc_pkg::RAD_W - 1){1'b0}}};

    assign busy  = busy_reg;
    assign root  = root_reg[adc_pkg::MAG_W-1:0];
    assign trial = (adc_pkg::RAD_W + 1)'(root_reg) + (adc_pkg::RAD_W + 1)'(bit_reg);

    always_comb
    begin
        rem_next  = rem_reg;
        root_next = root_reg;
        bit_next  = bit_reg;
        busy_next = busy_reg;
        if (start)
        begin
            rem_next  = radicand;
            root_next = '0;
            bit_next  = TOP_BIT;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if ((adc_pkg::RAD_W + 1)'(rem_reg) >= trial)
            begin
                rem_next  = rem_reg - trial[adc_pkg::RAD_W-1:0];
                root_next = (root_reg >> 1) + bit_reg;
            end
            else
                root_next = root_reg >> 1;
            bit_next  = bit_reg >> 2;
            busy_next = !bit_reg[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            busy_reg <= 1'b0;
        else
            busy_reg <= busy_next;
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        root_reg <= root_next;
        bit_reg  <= bit_next;
    end

endmodule

FILE: design/adc_back.sv
// Back end of the conditioner: shaping, slew limit against the last values,
// mixing, side rescale and the output register. Depends on adc_pkg and adc_isqrt.
module adc_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  adc_pkg::cfg_t                     cfg,
    input  adc_pkg::item_t                    head_item,
    input  logic                              queue_empty,
    output logic                              pop,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [adc_pkg::AXIS_W-1:0] left_drive,
    output logic signed [adc_pkg::AXIS_W-1:0] right_drive
);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_ROOT  = 6'b000010,
        ST_SHAPE = 6'b000100,
        ST_SLEW  = 6'b001000,
        ST_SCALE = 6'b010000,
        ST_OUT   = 6'b100000
    } state_t;

    localparam int SW = adc_pkg::STATE_W;
    localparam int PW = adc_pkg::PROD_W;

    function automatic logic signed [SW-1:0] slew_step(
        input logic signed [SW-1:0]           nv,
        input logic signed [SW-1:0]           prev,
        input logic [adc_pkg::LIM_W-1:0]      lim
    );
        logic signed [SW:0] diff, ad, an, ap, lim_s, moved;
        logic signed [SW-1:0] res;
        diff  = (SW + 1)'(nv) - (SW + 1)'(prev);
        ad    = diff[SW] ? -diff : diff;
        an    = nv[SW-1] ? -((SW + 1)'(nv)) : (SW + 1)'(nv);
        ap    = prev[SW-1] ? -((SW + 1)'(prev)) : (SW + 1)'(prev);
        lim_s = signed'((SW + 1)'(lim));
        moved = diff[SW] ? (SW + 1)'(prev) - lim_s : (SW + 1)'(prev) + lim_s;
        if (ad > lim_s && an > ap)
            res = moved[SW-1:0];
        else
            res = nv;
        return res;
    endfunction

    // The offset may exceed the scaled magnitude, so the difference folds back.
    function automatic logic signed [adc_pkg::AXIS_W-1:0] rescale_out(
        input logic [PW-1:0]                  p,
        input logic [adc_pkg::COEF_W-1:0]     off,
        input logic                           zero,
        input logic                           neg
    );
        logic signed [PW:0] m;
        logic signed [adc_pkg::AXIS_W-1:0] res;
        m = signed'((PW + 1)'(p)) - signed'((PW + 1)'(off));
        if (m < 0)
            m = -m;
        if (m > signed'((PW + 1)'(adc_pkg::ONE_MAG)))
            m = signed'((PW + 1)'(adc_pkg::ONE_MAG));
        if (zero)
            res = '0;
        else if (neg)
            res = adc_pkg::AXIS_W'(-m);
        else
            res = adc_pkg::AXIS_W'(m);
        return res;
    endfunction

    function automatic logic [PW-1:0] side_scale(
        input logic signed [SW-1:0]           v,
        input logic [adc_pkg::COEF_W-1:0]     gain
    );
        logic [adc_pkg::AXIS_W-1:0] mag;
        logic [adc_pkg::AXIS_W+adc_pkg::COEF_W-1:0] prod;
        mag  = v[SW-1] ? adc_pkg::AXIS_W'(-v) : adc_pkg::AXIS_W'(v);
        prod = mag * gain;
        return prod[adc_pkg::FRAC_W +: PW];
    endfunction

    state_t state_reg, state_next;

    logic                              speed_neg_reg, turn_neg_reg;
    logic [adc_pkg::LIM_W-1:0]         limit_reg;
    logic [adc_pkg::MAG_W-1:0]         sq_s_reg, sq_t_reg;
    logic signed [SW-1:0]              shaped_s_reg, shaped_t_reg;
    logic signed [SW-1:0]              last_s_reg, last_s_next;
    logic signed [SW-1:0]              last_t_reg, last_t_next;
    logic signed [SW-1:0]              left_sum_reg, right_sum_reg;
    logic [PW-1:0]                     left_prod_reg, right_prod_reg;
    logic                              left_zero_reg, right_zero_reg;
    logic                              left_neg_reg, right_neg_reg;
    logic                              out_valid_reg, out_valid_next;
    logic signed [adc_pkg::AXIS_W-1:0] left_reg, right_reg;

    logic [2*adc_pkg::MAG_W-1:0]       sq_s_full, sq_t_full, y_s_full, y_t_full;
    logic [adc_pkg::MAG_W-1:0]         y_s, y_t, root_s, root_t;
    logic                              busy_s, busy_t;
    logic signed [SW-1:0]              slew_s, slew_t;
    logic                              out_load;

    adc_isqrt u_root_speed (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (pop),
        .radicand ({head_item.speed_mag, {adc_pkg::FRAC_W{1'b0}}}),
        .busy     (busy_s),
        .root     (root_s)
    );

    adc_isqrt u_root_turn (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (pop),
        .radicand ({head_item.turn_mag, {adc_pkg::FRAC_W{1'b0}}}),
        .busy     (busy_t),
        .root     (root_t)
    );

    assign pop       = (state_reg == ST_IDLE) && !queue_empty;
    assign sq_s_full = head_item.speed_mag * head_item.speed_mag;
    assign sq_t_full = head_item.turn_mag * head_item.turn_mag;
    assign y_s_full  = sq_s_reg * root_s;
    assign y_t_full  = sq_t_reg * root_t;
    assign y_s       = y_s_full[adc_pkg::FRAC_W +: adc_pkg::MAG_W];
    assign y_t       = y_t_full[adc_pkg::FRAC_W +: adc_pkg::MAG_W];
    assign slew_s    = slew_step(shaped_s_reg, last_s_reg, limit_reg);
    assign slew_t    = slew_step(shaped_t_reg, last_t_reg, limit_reg);
    assign out_load  = (state_reg == ST_OUT) && (!out_valid_reg || !out_stall);

    assign out_valid   = out_valid_reg;
    assign left_drive  = left_reg;
    assign right_drive = right_reg;

    always_comb
    begin
        state_next     = state_reg;
        last_s_next    = last_s_reg;
        last_t_next    = last_t_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        unique case (state_reg)
            ST_IDLE:
                if (!queue_empty)
                    state_next = ST_ROOT;
            ST_ROOT:
                if (!busy_s && !busy_t)
                    state_next = ST_SHAPE;
            ST_SHAPE:
                state_next = ST_SLEW;
            ST_SLEW:
            begin
                last_s_next = slew_s;
                last_t_next = slew_t;
                state_next  = ST_SCALE;
            end
            ST_SCALE:
                state_next = ST_OUT;
            ST_OUT:
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            last_s_reg    <= '0;
            last_t_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            last_s_reg    <= last_s_next;
            last_t_reg    <= last_t_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            speed_neg_reg <= head_item.speed_neg;
            turn_neg_reg  <= head_item.turn_neg;
            limit_reg     <= head_item.limit;
            sq_s_reg      <= sq_s_full[adc_pkg::FRAC_W +: adc_pkg::MAG_W];
            sq_t_reg      <= sq_t_full[adc_pkg::FRAC_W +: adc_pkg::MAG_W];
        end
        if (state_reg == ST_SHAPE)
        begin
            shaped_s_reg <= speed_neg_reg ? -(SW'(y_s)) : SW'(y_s);
            shaped_t_reg <= turn_neg_reg ? -(SW'(y_t)) : SW'(y_t);
        end
        if (state_reg == ST_SLEW)
        begin
            left_sum_reg  <= slew_s + slew_t;
            right_sum_reg <= slew_s - slew_t;
        end
        if (state_reg == ST_SCALE)
        begin
            left_prod_reg  <= side_scale(left_sum_reg, cfg.left_gain);
            right_prod_reg <= side_scale(right_sum_reg, cfg.right_gain);
            left_zero_reg  <= (left_sum_reg == '0);
            right_zero_reg <= (right_sum_reg == '0);
            left_neg_reg   <= left_sum_reg[SW-1];
            right_neg_reg  <= right_sum_reg[SW-1];
        end
        if (out_load)
        begin
            left_reg  <= rescale_out(left_prod_reg, cfg.left_offset,
                                     left_zero_reg, left_neg_reg);
            right_reg <= rescale_out(right_prod_reg, cfg.right_offset,
                                     right_zero_reg, right_neg_reg);
        end
    end

endmodule

FILE: design/adc_checker.sv
// Port-level checks on the arcade drive conditioner over time, and the bind
// that attaches them to arcade_drive_conditioner_core. No package needed.
module adc_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic signed [15:0] left_drive,
    input logic signed [15:0] right_drive
);

    // Reset empties the queue and the output register by the following edge.
    a_reset_clear: assert property (@(posedge clk)
        !rst_n |=> !out_valid && !in_stall)
        else $error("reset left a result or a stall pending");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(left_drive) && $stable(right_drive))
        else $error("stalled result changed or vanished");

    a_drive_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> left_drive >= -16'sd16384 && left_drive <= 16'sd16384 &&
                      right_drive >= -16'sd16384 && right_drive <= 16'sd16384)
        else $error("drive command beyond full scale");

    // The queue only fills through an input transfer.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_stall) |-> $past(in_valid && !in_stall))
        else $error("input stall rose without a transfer");

endmodule

bind arcade_drive_conditioner_core adc_checker u_adc_checker (.*);

FILE: sim/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for arcade_drive_conditioner_core: random and directed
// joystick transfers are predicted in a scoreboard class and checked against each
// drive transfer. Depends on adc_pkg and the core it instantiates.
module tb;
    import adc_pkg::*;

    localparam longint UNITY        = longint'(1) << FRAC_W;
    localparam int     PIPE_CYCLES  = 30;
    localparam int     QUIET_LIMIT  = 5000;
    localparam int     PHASE_ITEMS  = 110;
    localparam int     LAST_PHASE   = 8;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

    typedef struct packed {
        logic signed [AXIS_W-1:0] left;
        logic signed [AXIS_W-1:0] right;
    } drive_pair_t;

    typedef logic [CFG_DATA_W-1:0] reg_words_t [7];

    // Predicts left and right drive from each accepted joystick transfer.
    class drive_checker;
        logic [DB_W-1:0]           db_speed, db_turn;
        logic [STEP_W-1:0]         max_step;
        logic [COEF_W-1:0]         left_gain, left_offset, right_gain, right_offset;
        logic signed [STATE_W-1:0] held_speed, held_turn;
        drive_pair_t               expected_drives[$];
        int                        mismatch_count;

        function new();
            db_speed       = '0;
            db_turn        = '0;
            max_step       = STEP_RESET;
            left_gain      = GAIN_RESET;
            left_offset    = '0;
            right_gain     = GAIN_RESET;
            right_offset   = '0;
            held_speed     = '0;
            held_turn      = '0;
            mismatch_count = 0;
        endfunction

        function longint mag(input longint v);
            return v < 0 ? -v : v;
        endfunction

        function logic [MAG_W-1:0] root_floor(input logic [RAD_W-1:0] n);
            logic [MAG_W-1:0] r;
            logic [MAG_W-1:0] trial;
            r = '0;
            for (int b = MAG_W - 1; b >= 0; b--)
            begin
                trial = r | (MAG_W'(1) << b);
                if (longint'(trial) * longint'(trial) <= longint'(n))
                    r = trial;
            end
            return r;
        endfunction

        // Deadband, saturation to 1.0, then |x|^2.5 as (x*x) times sqrt(x).
        function logic signed [STATE_W-1:0] shape(input logic signed [AXIS_W-1:0] x,
                                                  input logic [DB_W-1:0] db);
            longint v, a, sq, y;
            v = x;
            a = mag(v);
            if (a < longint'(db))
                return '0;
            if (a > UNITY)
                a = UNITY;
            sq = (a * a) >> FRAC_W;
            y  = (sq * longint'(root_floor(RAD_W'(a << FRAC_W)))) >> FRAC_W;
            return STATE_W'(v < 0 ? -y : y);
        endfunction

        // Only a move away from zero is limited; a move toward zero passes.
        function longint slew(input longint nv, input longint prev, input longint lim);
            longint d;
            d = nv - prev;
            if (mag(d) > lim && mag(nv) > mag(prev))
                return d < 0 ? prev - lim : prev + lim;
            return nv;
        endfunction

        function logic signed [AXIS_W-1:0] rescale(input longint v,
                                                   input logic [COEF_W-1:0] gain,
                                                   input logic [COEF_W-1:0] offset);
            longint m;
            if (v == 0)
                return '0;
            m = mag(((mag(v) * longint'(gain)) >> FRAC_W) - longint'(offset));
            if (m > UNITY)
                m = UNITY;
            return AXIS_W'(v < 0 ? -m : m);
        endfunction

        function void set_reg(input logic [CFG_IDX_W-1:0] idx,
                              input logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_DB_SPEED:     db_speed     = val[DB_W-1:0];
                REG_DB_TURN:      db_turn      = val[DB_W-1:0];
                REG_MAX_STEP:     max_step     = val[STEP_W-1:0];
                REG_LEFT_GAIN:    left_gain    = val[COEF_W-1:0];
                REG_LEFT_OFFSET:  left_offset  = val[COEF_W-1:0];
                REG_RIGHT_GAIN:   right_gain   = val[COEF_W-1:0];
                REG_RIGHT_OFFSET: right_offset = val[COEF_W-1:0];
                default: ;
            endcase
        endfunction

        function void predict_drive(input logic signed [AXIS_W-1:0] s,
                                    input logic signed [AXIS_W-1:0] t,
                                    input logic [TICK_W-1:0] ticks);
            longint lim, s_new, t_new;
            drive_pair_t p;
            lim = longint'(max_step) * longint'(ticks);
            if (lim > 2 * UNITY)
                lim = 2 * UNITY;
            s_new = slew(shape(s, db_speed), held_speed, lim);
            t_new = slew(shape(t, db_turn), held_turn, lim);
            held_speed = STATE_W'(s_new);
            held_turn  = STATE_W'(t_new);
            p.left  = rescale(s_new + t_new, left_gain, left_offset);
            p.right = rescale(s_new - t_new, right_gain, right_offset);
            expected_drives = {expected_drives, p};
        endfunction

        function void check_drive(input logic signed [AXIS_W-1:0] left_val,
                                  input logic signed [AXIS_W-1:0] right_val);
            drive_pair_t p;
            if (expected_drives.size() == 0)
            begin
                $error("unexpected drive transfer: left_drive %0d right_drive %0d",
                       left_val, right_val);
                mismatch_count++;
                return;
            end
            p = expected_drives.pop_front();
            if (left_val !== p.left)
            begin
                $error("left_drive: expected %0d, got %0d", p.left, left_val);
                mismatch_count++;
            end
            if (right_val !== p.right)
            begin
                $error("right_drive: expected %0d, got %0d", p.right, right_val);
                mismatch_count++;
            end
        endfunction

        function int pending();
            return expected_drives.size();
        endfunction
    endclass

    logic                     clk           = 1'b0;
    logic                     rst_n         = 1'b0;
    logic                     in_valid      = 1'b0;
    logic                     in_stall;
    logic signed [AXIS_W-1:0] speed_axis    = '0;
    logic signed [AXIS_W-1:0] turn_axis     = '0;
    logic [TICK_W-1:0]        elapsed_ticks = '0;
    logic                     out_valid;
    logic                     out_stall     = 1'b0;
    logic signed [AXIS_W-1:0] left_drive;
    logic signed [AXIS_W-1:0] right_drive;
    logic                     cfg_write     = 1'b0;
    logic [CFG_IDX_W-1:0]     cfg_index     = '0;
    logic [CFG_DATA_W-1:0]    cfg_data      = '0;

    logic idle_on      = 1'b1;
    int   stall_left   = 0;
    int   quiet_cycles = 0;

    drive_checker sb;

    arcade_drive_conditioner_core i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .speed_axis    (speed_axis),
        .turn_axis     (turn_axis),
        .elapsed_ticks (elapsed_ticks),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .left_drive    (left_drive),
        .right_drive   (right_drive),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    // Output back-pressure in random bursts, begun only while idle_on is set.
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_stall  <= 1'b1;
        end
        else if (rst_n && idle_on && $urandom_range(0, 5) == 0)
        begin
            stall_left <= $urandom_range(0, 10);
            out_stall  <= 1'b1;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_drive(left_drive, right_drive);
    end

    // Ends the run when no transfer happens on either channel for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    task automatic send_item(input logic signed [AXIS_W-1:0] s,
                             input logic signed [AXIS_W-1:0] t,
                             input logic [TICK_W-1:0] ticks);
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        in_valid      <= 1'b1;
        speed_axis    <= s;
        turn_axis     <= t;
        elapsed_ticks <= ticks;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.predict_drive(s, t, ticks);
    endtask

    function automatic logic signed [AXIS_W-1:0] pick_axis(input logic [DB_W-1:0] db);
        int v;
        case ($urandom_range(0, 7))
            0: v = $urandom_range(0, 65535) - 32768;
            1:
            begin
                case ($urandom_range(0, 4))
                    0: v = 16384;
                    1: v = -16384;
                    2: v = 32767;
                    3: v = -32768;
                    default: v = 0;
                endcase
            end
            2:
            begin
                v = int'(db) + int'($urandom_range(0, 4)) - 2;
                if ($urandom_range(0, 1) == 1)
                    v = -v;
            end
            default: v = int'($urandom_range(0, 32768)) - 16384;
        endcase
        return AXIS_W'(v);
    endfunction

    function automatic logic [TICK_W-1:0] pick_ticks();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return TICK_W'($urandom);
            2: return '1;
            default: return TICK_W'($urandom_range(0, 300));
        endcase
    endfunction

    task automatic run_random(input int count);
        for (int i = 0; i < count; i++)
            send_item(pick_axis(sb.db_speed), pick_axis(sb.db_turn), pick_ticks());
    endtask

    // Lets every pending drive transfer arrive before the registers change.
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (PIPE_CYCLES) @(posedge clk);
    endtask

    task automatic program_regs(input reg_words_t w);
        cfg_index_t r;
        logic [CFG_DATA_W-1:0] junk;
        r = r.first();
        do
        begin
            cfg_write <= 1'b1;
            cfg_index <= r;
            cfg_data  <= w[r];
            @(posedge clk);
            sb.set_reg(r, w[r]);
            r = r.next();
        end
        while (r != r.first());
        // The spare index must not disturb any register.
        junk = CFG_DATA_W'($urandom);
        cfg_index <= REG_SPARE;
        cfg_data  <= junk;
        @(posedge clk);
        sb.set_reg(REG_SPARE, junk);
        cfg_write <= 1'b0;
    endtask

    function automatic reg_words_t pick_regs(input int phase);
        reg_words_t w;
        case (phase)
            1:
            begin
                w[REG_DB_SPEED]     = 8191;
                w[REG_DB_TURN]      = 8191;
                w[REG_MAX_STEP]     = 16384;
                w[REG_LEFT_GAIN]    = 32767;
                w[REG_LEFT_OFFSET]  = 16384;
                w[REG_RIGHT_GAIN]   = 32767;
                w[REG_RIGHT_OFFSET] = 16384;
            end
            2:
            begin
                w[REG_DB_SPEED]     = 0;
                w[REG_DB_TURN]      = 0;
                w[REG_MAX_STEP]     = 0;
                w[REG_LEFT_GAIN]    = GAIN_RESET;
                w[REG_LEFT_OFFSET]  = 0;
                w[REG_RIGHT_GAIN]   = GAIN_RESET;
                w[REG_RIGHT_OFFSET] = 0;
            end
            3:
            begin
                foreach (w[i])
                    w[i] = '1;
            end
            default:
            begin
                w[REG_DB_SPEED]     = CFG_DATA_W'($urandom_range(0, 8191));
                w[REG_DB_TURN]      = CFG_DATA_W'($urandom_range(0, 8191));
                w[REG_MAX_STEP]     = $urandom_range(0, 3) == 0
                                      ? CFG_DATA_W'($urandom)
                                      : CFG_DATA_W'($urandom_range(1, 400));
                w[REG_LEFT_GAIN]    = CFG_DATA_W'($urandom_range(16384, 32767));
                w[REG_LEFT_OFFSET]  = CFG_DATA_W'($urandom_range(0, 16384));
                w[REG_RIGHT_GAIN]   = CFG_DATA_W'($urandom_range(16384, 32767));
                w[REG_RIGHT_OFFSET] = CFG_DATA_W'($urandom_range(0, 16384));
                if ($urandom_range(0, 2) == 0)
                begin
                    w[REG_DB_SPEED] = CFG_DATA_W'($urandom);
                    w[REG_DB_TURN]  = CFG_DATA_W'($urandom);
                    w[REG_LEFT_GAIN]   = CFG_DATA_W'($urandom);
                    w[REG_RIGHT_OFFSET] = CFG_DATA_W'($urandom);
                end
            end
        endcase
        return w;
    endfunction

    initial
    begin
        sb = new();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: full deflection, saturation, zero and maximum tick counts.
        send_item(0, 0, 0);
        send_item(16384, 0, 0);
        send_item(16384, 0, 16'hFFFF);
        send_item(-16384, 0, 16'hFFFF);
        send_item(16384, 16384, 16'hFFFF);
        send_item(-16384, 16384, 16'hFFFF);
        send_item(32767, -32768, 16'hFFFF);
        send_item(-32768, 32767, 16'hFFFF);
        send_item(0, 0, 1);
        send_item(1, -1, 1);
        send_item(16383, -16383, 200);
        send_item(-16384, -16384, 100);
        send_item(8192, -8192, 0);
        send_item(0, 16384, 16'hFFFF);
        send_item(-32768, -32768, 16'hFFFF);
        send_item(16384, -16384, 16'hFFFF);
        send_item(0, 0, 16'hFFFF);
        run_random(PHASE_ITEMS - 17);

        for (int phase = 1; phase <= LAST_PHASE; phase++)
        begin
            drain();
            idle_on <= (phase != LAST_PHASE) && ($urandom_range(0, 3) != 0);
            program_regs(pick_regs(phase));
            run_random(PHASE_ITEMS);
        end

        drain();
        if (sb.mismatch_count == 0 && sb.pending() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

FILE: arcade_drive_conditioner_core.f
design/adc_pkg.sv
design/adc_front.sv
design/adc_queue.sv
design/adc_isqrt.sv
design/adc_back.sv
design/arcade_drive_conditioner_core.sv
design/adc_checker.sv
sim/tb.sv
